/* hw/rtl/char_lcd_nibble_write_sequencer_defines.svh */
// Assertion macros for the character LCD nibble write sequencer.
// Used by the port checker; depends on clk and rst_n in the including scope.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CLCD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clcd check failed");

// next-cycle implication, checked outside reset
`define CLCD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clcd check failed");

`endif

/* hw/rtl/clcd_pkg.sv */
// Shared types, constants and the init script table for the LCD sequencer.
// No dependencies.
package clcd_pkg;

  localparam int NIB_W  = 4;
  localparam int BYTE_W = 8;
  localparam int HOLD_W = 17;
  localparam int REQ_W  = 3;
  localparam int COL_W  = 5;
  localparam int ROW_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int TDATA_IN_W  = 24;
  localparam int TDATA_OUT_W = 24;

  localparam logic [HOLD_W-1:0] ENABLE_US     = 17'd10;
  localparam logic [HOLD_W-1:0] POWER_UP_US   = 17'd100000;
  localparam logic [HOLD_W-1:0] RESET1_US     = 17'd10000;
  localparam logic [HOLD_W-1:0] RESET2_US     = 17'd200;
  localparam logic [HOLD_W-1:0] CMD_US        = 17'd80;
  localparam logic [HOLD_W-1:0] INIT_CLEAR_US = 17'd4000;
  localparam logic [HOLD_W-1:0] CLEAR_US      = 17'd2000;
  localparam logic [HOLD_W-1:0] GOTO_US       = 17'd50;
  localparam logic [HOLD_W-1:0] NO_EXTRA_US   = 17'd0;

  localparam logic [BYTE_W-1:0] DDRAM_BASE = 8'h80;
  localparam logic [COL_W-1:0]  COLS = 5'd16;
  localparam logic [ROW_W-1:0]  ROWS = 2'd2;

  localparam logic [NIB_W-1:0] INIT_LAST_NIB = 4'd13;
  localparam logic [NIB_W-1:0] BYTE_LAST_NIB = 4'd1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT  = 3'd0,
    REQ_CHAR  = 3'd1,
    REQ_CMD   = 3'd2,
    REQ_CLEAR = 3'd3,
    REQ_GOTO  = 3'd4
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET   = 3'd0,
    REG_FSET    = 3'd1,
    REG_DOFF    = 3'd2,
    REG_CLEAR   = 3'd3,
    REG_ENTRY   = 3'd4,
    REG_DON     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] reset_cmd;
    logic [BYTE_W-1:0] function_set_cmd;
    logic [BYTE_W-1:0] display_off_cmd;
    logic [BYTE_W-1:0] clear_cmd;
    logic [BYTE_W-1:0] entry_mode_cmd;
    logic [BYTE_W-1:0] display_on_cmd;
  } cfg_t;

  typedef enum logic [1:0] {
    JOB_INIT = 2'd0,
    JOB_BYTE = 2'd1,
    JOB_ERR  = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [BYTE_W-1:0] byte_val;
    logic              rs;
    logic [HOLD_W-1:0] extra;
  } job_t;

  typedef enum logic [2:0] {
    SRC_RESET = 3'd0,
    SRC_FSET  = 3'd1,
    SRC_DOFF  = 3'd2,
    SRC_CLEAR = 3'd3,
    SRC_ENTRY = 3'd4,
    SRC_DON   = 3'd5
  } init_src_t;

  typedef struct packed {
    init_src_t         src;
    logic              upper;
    logic [HOLD_W-1:0] extra;
  } init_step_t;

  // init script: nibble index -> source byte, which half, extra wait
  function automatic init_step_t init_step(input logic [NIB_W-1:0] n);
    init_step_t s;
    case (n)
      4'd0:    s = '{SRC_RESET, 1'b1, RESET1_US};
      4'd1:    s = '{SRC_RESET, 1'b1, RESET2_US};
      4'd2:    s = '{SRC_RESET, 1'b1, RESET2_US};
      4'd3:    s = '{SRC_FSET,  1'b1, CMD_US};
      4'd4:    s = '{SRC_FSET,  1'b1, NO_EXTRA_US};
      4'd5:    s = '{SRC_FSET,  1'b0, CMD_US};
      4'd6:    s = '{SRC_DOFF,  1'b1, NO_EXTRA_US};
      4'd7:    s = '{SRC_DOFF,  1'b0, CMD_US};
      4'd8:    s = '{SRC_CLEAR, 1'b1, NO_EXTRA_US};
      4'd9:    s = '{SRC_CLEAR, 1'b0, INIT_CLEAR_US};
      4'd10:   s = '{SRC_ENTRY, 1'b1, NO_EXTRA_US};
      4'd11:   s = '{SRC_ENTRY, 1'b0, CMD_US};
      4'd12:   s = '{SRC_DON,   1'b1, NO_EXTRA_US};
      4'd13:   s = '{SRC_DON,   1'b0, CMD_US};
      default: s = '{SRC_DON,   1'b0, NO_EXTRA_US};
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/clcd_queue.sv */
// Two-entry job queue between the request classifier and the pin sequencer.
// Depends on clcd_pkg.
module clcd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  clcd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output clcd_pkg::job_t head_job
);

  clcd_pkg::job_t                mem_r [clcd_pkg::QUEUE_DEPTH];
  logic [clcd_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [clcd_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [clcd_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  localparam logic [clcd_pkg::QPTR_W-1:0] PTR_LAST = clcd_pkg::QPTR_W'(clcd_pkg::QUEUE_DEPTH - 1);

  assign full     = (cnt_r == clcd_pkg::QCNT_W'(clcd_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* hw/rtl/clcd_front.sv */
// Request classifier: takes requests, checks goto range, builds sequencer jobs.
// Depends on clcd_pkg.
module clcd_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [clcd_pkg::REQ_W-1:0]     req_type,
  input  logic [clcd_pkg::BYTE_W-1:0]    data_byte,
  input  logic [clcd_pkg::COL_W-1:0]     column,
  input  logic [clcd_pkg::ROW_W-1:0]     row,
  input  logic [clcd_pkg::BYTE_W-1:0]    clear_cmd,
  input  logic                           q_full,
  output logic                           q_push,
  output clcd_pkg::job_t                 q_job
);

  logic                           known;
  logic                           pos_ok;
  logic [clcd_pkg::BYTE_W-1:0]    goto_byte;

  assign in_tready = !q_full;
  assign pos_ok    = (row < clcd_pkg::ROWS) && (column < clcd_pkg::COLS);
  assign goto_byte = (clcd_pkg::DDRAM_BASE | {row[0], 6'b0}) + {3'b0, column};

  always_comb begin
    known = 1'b1;
    q_job = '{clcd_pkg::JOB_BYTE, data_byte, 1'b0, clcd_pkg::NO_EXTRA_US};
    case (req_type)
      clcd_pkg::REQ_INIT: begin
        q_job.kind = clcd_pkg::JOB_INIT;
      end
      clcd_pkg::REQ_CHAR: begin
        q_job.rs = 1'b1;
      end
      clcd_pkg::REQ_CMD: begin
        q_job.rs = 1'b0;
      end
      clcd_pkg::REQ_CLEAR: begin
        q_job.byte_val = clear_cmd;
        q_job.extra    = clcd_pkg::CLEAR_US;
      end
      clcd_pkg::REQ_GOTO: begin
        if (pos_ok) begin
          q_job.byte_val = goto_byte;
          q_job.extra    = clcd_pkg::GOTO_US;
        end else begin
          q_job.kind = clcd_pkg::JOB_ERR;
        end
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unknown request types are taken and dropped
  assign q_push = in_tvalid && in_tready && known;

endmodule

/* hw/rtl/clcd_back.sv */
// Pin-state sequencer: expands queued jobs into LCD pin states, one per cycle unless stalled.
// Depends on clcd_pkg.
module clcd_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  clcd_pkg::cfg_t                      cfg,
  input  logic                                q_empty,
  input  clcd_pkg::job_t                      q_job,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [clcd_pkg::TDATA_OUT_W-1:0]    out_tdata,
  output logic                                out_tuser,
  output logic                                out_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POWER,
    ST_NIB,
    ST_ERR
  } state_t;

  state_t                           state_r, state_nxt;
  clcd_pkg::job_t                   job_r, job_nxt;
  logic [clcd_pkg::NIB_W-1:0]       nib_r, nib_nxt;
  logic                             ph_r, ph_nxt;
  logic                             rs_level_r, rs_level_nxt;
  logic [clcd_pkg::NIB_W-1:0]       data_level_r, data_level_nxt;
  logic                             valid_r, valid_nxt;
  logic [clcd_pkg::TDATA_OUT_W-1:0] tdata_r, tdata_nxt;
  logic                             tuser_r, tuser_nxt;
  logic                             tlast_r, tlast_nxt;

  logic                             adv;
  logic                             is_init;
  clcd_pkg::init_step_t             step;
  logic [clcd_pkg::BYTE_W-1:0]      src_byte;
  logic                             upper;
  logic [clcd_pkg::NIB_W-1:0]       cur_nib;
  logic [clcd_pkg::HOLD_W-1:0]      extra;
  logic [clcd_pkg::HOLD_W-1:0]      hold;
  logic                             cur_rs;
  logic [clcd_pkg::NIB_W-1:0]       last_nib;
  logic                             is_last;

  assign adv     = !valid_r || out_tready;
  assign is_init = (job_r.kind == clcd_pkg::JOB_INIT);
  assign step    = clcd_pkg::init_step(nib_r);

  always_comb begin
    case (step.src)
      clcd_pkg::SRC_RESET: src_byte = cfg.reset_cmd;
      clcd_pkg::SRC_FSET:  src_byte = cfg.function_set_cmd;
      clcd_pkg::SRC_DOFF:  src_byte = cfg.display_off_cmd;
      clcd_pkg::SRC_CLEAR: src_byte = cfg.clear_cmd;
      clcd_pkg::SRC_ENTRY: src_byte = cfg.entry_mode_cmd;
      clcd_pkg::SRC_DON:   src_byte = cfg.display_on_cmd;
      default:             src_byte = cfg.display_on_cmd;
    endcase
    if (is_init) begin
      upper    = step.upper;
      cur_nib  = upper ? src_byte[7:4] : src_byte[3:0];
      extra    = step.extra;
      cur_rs   = 1'b0;
      last_nib = clcd_pkg::INIT_LAST_NIB;
    end else begin
      upper    = (nib_r == '0);
      cur_nib  = upper ? job_r.byte_val[7:4] : job_r.byte_val[3:0];
      extra    = (nib_r == clcd_pkg::BYTE_LAST_NIB) ? job_r.extra : clcd_pkg::NO_EXTRA_US;
      cur_rs   = job_r.rs;
      last_nib = clcd_pkg::BYTE_LAST_NIB;
    end
    hold    = clcd_pkg::ENABLE_US + (ph_r ? extra : clcd_pkg::NO_EXTRA_US);
    is_last = ph_r && (nib_r == last_nib);
  end

  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    nib_nxt        = nib_r;
    ph_nxt         = ph_r;
    rs_level_nxt   = rs_level_r;
    data_level_nxt = data_level_r;
    valid_nxt      = valid_r && !out_tready;
    tdata_nxt      = tdata_r;
    tuser_nxt      = tuser_r;
    tlast_nxt      = tlast_r;
    q_pop          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          nib_nxt = '0;
          ph_nxt  = 1'b0;
          case (q_job.kind)
            clcd_pkg::JOB_INIT: state_nxt = ST_POWER;
            clcd_pkg::JOB_ERR:  state_nxt = ST_ERR;
            default:            state_nxt = ST_NIB;
          endcase
        end
      end
      ST_POWER: begin
        if (adv) begin
          valid_nxt    = 1'b1;
          tdata_nxt    = {1'b0, 1'b0, clcd_pkg::POWER_UP_US, 1'b0, data_level_r};
          tuser_nxt    = 1'b0;
          tlast_nxt    = 1'b0;
          rs_level_nxt = 1'b0;
          state_nxt    = ST_NIB;
        end
      end
      ST_NIB: begin
        if (adv) begin
          valid_nxt      = 1'b1;
          tdata_nxt      = {1'b0, 1'b0, hold, !ph_r, cur_nib};
          tuser_nxt      = cur_rs;
          tlast_nxt      = is_last;
          rs_level_nxt   = cur_rs;
          data_level_nxt = cur_nib;
          ph_nxt         = !ph_r;
          if (ph_r) begin
            nib_nxt = nib_r + 1'b1;
          end
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (adv) begin
          valid_nxt = 1'b1;
          tdata_nxt = {1'b0, 1'b1, clcd_pkg::NO_EXTRA_US, 1'b0, data_level_r};
          tuser_nxt = rs_level_r;
          tlast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= 1'b0;
      rs_level_r   <= 1'b0;
      data_level_r <= '0;
      nib_r        <= '0;
      ph_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      rs_level_r   <= rs_level_nxt;
      data_level_r <= data_level_nxt;
      nib_r        <= nib_nxt;
      ph_r         <= ph_nxt;
    end
    job_r   <= job_nxt;
    tdata_r <= tdata_nxt;
    tuser_r <= tuser_nxt;
    tlast_r <= tlast_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r;
  assign out_tlast  = tlast_r;

endmodule

/* hw/rtl/char_lcd_nibble_write_sequencer.sv */
// Top level of the 4-bit character LCD write sequencer: command registers,
// request classifier, job queue and pin-state sequencer. Depends on clcd_pkg.
//
// Each request becomes a run of LCD pin states on the output stream, one
// state per cycle while out_tready is high: init gives 29 states, write
// character, write command, clear and an in-range goto give 4, an
// out-of-range goto gives 1 error state, and request types 5..7 give none.
// The sequencer takes each job from a two-deep queue in its idle state
// before it emits the job's states; the classifier keeps taking requests
// until the queue is full. Command registers may be written only while
// no run is pending.
module char_lcd_nibble_write_sequencer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // req_type[2:0], data_byte[10:3], column[15:11], row[17:16], zero fill
  input  logic [clcd_pkg::TDATA_IN_W-1:0]       in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // data_nibble[3:0], enable_line[4], hold_us[21:5], status[22], zero fill
  output logic [clcd_pkg::TDATA_OUT_W-1:0]      out_tdata,
  // reg_select[0]
  output logic                                  out_tuser,
  output logic                                  out_tlast,
  input  logic                                  cfg_we,
  input  logic [clcd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [clcd_pkg::BYTE_W-1:0]           cfg_wdata
);

  clcd_pkg::cfg_t cfg_r, cfg_nxt;
  clcd_pkg::job_t push_job, head_job;
  logic           q_full, q_empty, q_push, q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        clcd_pkg::REG_RESET: cfg_nxt.reset_cmd        = cfg_wdata;
        clcd_pkg::REG_FSET:  cfg_nxt.function_set_cmd = cfg_wdata;
        clcd_pkg::REG_DOFF:  cfg_nxt.display_off_cmd  = cfg_wdata;
        clcd_pkg::REG_CLEAR: cfg_nxt.clear_cmd        = cfg_wdata;
        clcd_pkg::REG_ENTRY: cfg_nxt.entry_mode_cmd   = cfg_wdata;
        clcd_pkg::REG_DON:   cfg_nxt.display_on_cmd   = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{8'h30, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  clcd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .req_type  (in_tdata[2:0]),
    .data_byte (in_tdata[10:3]),
    .column    (in_tdata[15:11]),
    .row       (in_tdata[17:16]),
    .clear_cmd (cfg_r.clear_cmd),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  clcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  clcd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* hw/rtl/clcd_chk.sv */
// Port checker for the LCD sequencer output stream, bound to the top level.
// Depends on clcd_pkg and char_lcd_nibble_write_sequencer_defines.svh.
`include "char_lcd_nibble_write_sequencer_defines.svh"

module clcd_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [clcd_pkg::TDATA_OUT_W-1:0]   out_tdata,
  input logic                               out_tuser,
  input logic                               out_tlast
);

  // stalled transaction holds
  `CLCD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // strobe-high state is always the first half of a nibble
  `CLCD_ASSERT_IMP(a_e_high_not_last, out_tvalid && out_tdata[4], !out_tlast && out_tdata[21:5] == clcd_pkg::ENABLE_US)

  // error state ends its run with E low and no hold
  `CLCD_ASSERT_IMP(a_err_state, out_tvalid && out_tdata[22], out_tlast && !out_tdata[4] && out_tdata[21:5] == clcd_pkg::NO_EXTRA_US)

  // fill bit stays zero
  `CLCD_ASSERT_IMP(a_fill_zero, out_tvalid, !out_tdata[23])

endmodule

bind char_lcd_nibble_write_sequencer clcd_chk u_clcd_chk (.*);

/* tb/char_lcd_nibble_write_sequencer_tb.sv */
// Self-checking testbench for the 4-bit character LCD write sequencer.
// Predicts the pin-state run of every request and checks the output stream;
// depends on clcd_pkg and char_lcd_nibble_write_sequencer.
module char_lcd_nibble_write_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clcd_pkg::*;

  localparam logic [16:0] STROBE_US     = 17'd10;
  localparam logic [16:0] POWER_WAIT_US = 17'd100000;
  localparam logic [16:0] RESET1_WAIT   = 17'd10000;
  localparam logic [16:0] RESET2_WAIT   = 17'd200;
  localparam logic [16:0] CMD_WAIT      = 17'd80;
  localparam logic [16:0] INIT_CLR_WAIT = 17'd4000;
  localparam logic [16:0] CLR_WAIT      = 17'd2000;
  localparam logic [16:0] GOTO_WAIT     = 17'd50;
  localparam logic [16:0] NO_WAIT       = 17'd0;
  localparam logic [7:0]  SET_DDRAM     = 8'h80;

  // req in the low bits, row in the high bits
  typedef struct packed {
    logic [1:0] row;
    logic [4:0] column;
    logic [7:0] data_byte;
    logic [2:0] req;
  } lcd_req_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        rs;
    logic        en;
    logic [16:0] hold;
    logic        status;
    logic        last;
  } pin_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_RESET;
  logic [7:0]  cfg_wdata = '0;

  // predictor state
  logic [7:0] cmd_regs [6];
  logic       rs_now;
  logic [3:0] data_now;

  lcd_req_t   req_backlog[$];
  pin_state_t pin_states_due[$];
  int unsigned mismatch_count = 0;

  char_lcd_nibble_write_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic void add_pin_state(logic [3:0] nib, logic rs, logic en,
                                        logic [16:0] hold, logic status);
    data_now = nib;
    rs_now   = rs;
    pin_states_due.push_back('{nib, rs, en, hold, status, 1'b0});
  endfunction

  function automatic void add_nibble(logic [3:0] nib, logic rs, logic [16:0] extra);
    add_pin_state(nib, rs, 1'b1, STROBE_US, 1'b0);
    add_pin_state(nib, rs, 1'b0, STROBE_US + extra, 1'b0);
  endfunction

  function automatic void add_byte(logic [7:0] b, logic rs, logic [16:0] extra);
    add_nibble(b[7:4], rs, NO_WAIT);
    add_nibble(b[3:0], rs, extra);
  endfunction

  function automatic void predict_request(lcd_req_t r);
    int unsigned before_cnt;
    pin_state_t  tail;
    before_cnt = pin_states_due.size();
    case (r.req)
      REQ_INIT: begin
        add_pin_state(data_now, 1'b0, 1'b0, POWER_WAIT_US, 1'b0);
        add_nibble(cmd_regs[REG_RESET][7:4], 1'b0, RESET1_WAIT);
        add_nibble(cmd_regs[REG_RESET][7:4], 1'b0, RESET2_WAIT);
        add_nibble(cmd_regs[REG_RESET][7:4], 1'b0, RESET2_WAIT);
        add_nibble(cmd_regs[REG_FSET][7:4], 1'b0, CMD_WAIT);
        add_byte(cmd_regs[REG_FSET], 1'b0, CMD_WAIT);
        add_byte(cmd_regs[REG_DOFF], 1'b0, CMD_WAIT);
        add_byte(cmd_regs[REG_CLEAR], 1'b0, INIT_CLR_WAIT);
        add_byte(cmd_regs[REG_ENTRY], 1'b0, CMD_WAIT);
        add_byte(cmd_regs[REG_DON], 1'b0, CMD_WAIT);
      end
      REQ_CHAR:  add_byte(r.data_byte, 1'b1, NO_WAIT);
      REQ_CMD:   add_byte(r.data_byte, 1'b0, NO_WAIT);
      REQ_CLEAR: add_byte(cmd_regs[REG_CLEAR], 1'b0, CLR_WAIT);
      REQ_GOTO: begin
        if (r.row < 2'd2 && r.column < 5'd16)
          add_byte((SET_DDRAM | {r.row, 6'd0}) + {3'd0, r.column}, 1'b0, GOTO_WAIT);
        else
          add_pin_state(data_now, rs_now, 1'b0, NO_WAIT, 1'b1);
      end
      default: ;
    endcase
    if (pin_states_due.size() > before_cnt) begin
      tail = pin_states_due[pin_states_due.size()-1];
      tail.last = 1'b1;
      pin_states_due[pin_states_due.size()-1] = tail;
    end
  endfunction

  // ---------------- request driver ----------------
  int unsigned burst_left, gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        in_tdata  <= {6'd0, req_backlog.pop_front()} ;
        in_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(0, 10);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- result receiver ----------------
  int unsigned reqs_taken, hold_off_left, mode_left, stall_mode;
  logic        hold_off_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready    <= 1'b0;
      reqs_taken    <= 0;
      hold_off_left <= 0;
      hold_off_done <= 1'b0;
      mode_left     <= 0;
      stall_mode    <= 0;
    end else begin
      if (in_tvalid && in_tready) reqs_taken <= reqs_taken + 1;
      if (hold_off_left != 0) begin
        hold_off_left <= hold_off_left - 1;
        out_tready    <= 1'b0;
      end else if (reqs_taken == 60 && !hold_off_done) begin
        // long back-pressure: the job queue fills and in_tready drops
        hold_off_left <= 400;
        hold_off_done <= 1'b1;
        out_tready    <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 2);
          mode_left  <= $urandom_range(16, 96);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------- checker ----------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    pin_state_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_request(lcd_req_t'(in_tdata[17:0]));
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[3:0], out_tuser, out_tdata[4], out_tdata[21:5],
                out_tdata[22], out_tlast};
        if (pin_states_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected pin state, expected none, actual %h", $time, got);
        end else begin
          want = pin_states_due.pop_front();
          check_field("data_nibble", 32'(want.nibble), 32'(got.nibble));
          check_field("reg_select", 32'(want.rs), 32'(got.rs));
          check_field("enable_line", 32'(want.en), 32'(got.en));
          check_field("hold_us", 32'(want.hold), 32'(got.hold));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("last", 32'(want.last), 32'(got.last));
        end
      end
    end
  end

  // ---------------- sequence ----------------
  task automatic write_cmd_reg(reg_idx_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    cmd_regs[idx] = val;
  endtask

  task automatic end_cfg_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all_regs(logic [7:0] val);
    reg_idx_t r;
    r = r.first();
    repeat (r.num()) begin
      write_cmd_reg(r, val);
      r = r.next();
    end
    end_cfg_writes();
  endtask

  task automatic wait_until_idle();
    while (req_backlog.size() != 0 || in_tvalid || pin_states_due.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic void queue_req(logic [2:0] req, logic [7:0] db,
                                    logic [4:0] col, logic [1:0] row);
    req_backlog.push_back('{row, col, db, req});
  endfunction

  function automatic lcd_req_t random_request();
    lcd_req_t    r;
    int unsigned pick;
    r.data_byte = 8'($urandom_range(0, 255));
    r.column    = 5'($urandom_range(0, 31));
    r.row       = 2'($urandom_range(0, 3));
    pick        = $urandom_range(0, 99);
    if (pick < 8)       r.req = REQ_INIT;
    else if (pick < 38) r.req = REQ_CHAR;
    else if (pick < 58) r.req = REQ_CMD;
    else if (pick < 68) r.req = REQ_CLEAR;
    else if (pick < 93) begin
      r.req = REQ_GOTO;
      if ($urandom_range(0, 4) != 0) begin
        r.column = 5'($urandom_range(0, 15));
        r.row    = 2'($urandom_range(0, 1));
      end
    end else r.req = 3'($urandom_range(5, 7));
    return r;
  endfunction

  initial begin
    reg_idx_t r;
    cmd_regs[REG_RESET] = 8'h30;
    cmd_regs[REG_FSET]  = 8'h28;
    cmd_regs[REG_DOFF]  = 8'h08;
    cmd_regs[REG_CLEAR] = 8'h01;
    cmd_regs[REG_ENTRY] = 8'h06;
    cmd_regs[REG_DON]   = 8'h0C;
    rs_now   = 1'b0;
    data_now = 4'h0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values
    queue_req(REQ_INIT, 8'h00, 5'd0, 2'd0);
    queue_req(REQ_CHAR, 8'h00, 5'd0, 2'd0);
    queue_req(REQ_CHAR, 8'hFF, 5'd31, 2'd3);
    queue_req(REQ_CHAR, 8'hA5, 5'd0, 2'd0);
    queue_req(REQ_GOTO, 8'h00, 5'd16, 2'd0);   // bad column, RS still high
    queue_req(REQ_INIT, 8'h00, 5'd0, 2'd0);    // power-up state keeps D7..D4
    queue_req(REQ_CMD, 8'h00, 5'd0, 2'd0);
    queue_req(REQ_CMD, 8'hFF, 5'd31, 2'd3);
    queue_req(REQ_CLEAR, 8'h5A, 5'd7, 2'd1);
    queue_req(REQ_GOTO, 8'hFF, 5'd0, 2'd0);
    queue_req(REQ_GOTO, 8'h00, 5'd15, 2'd1);
    queue_req(REQ_GOTO, 8'h00, 5'd15, 2'd0);
    queue_req(REQ_GOTO, 8'h00, 5'd0, 2'd1);
    queue_req(REQ_GOTO, 8'h00, 5'd31, 2'd0);
    queue_req(REQ_GOTO, 8'h00, 5'd0, 2'd2);
    queue_req(REQ_GOTO, 8'h00, 5'd3, 2'd3);
    queue_req(REQ_GOTO, 8'hFF, 5'd31, 2'd3);
    queue_req(3'd5, 8'h3C, 5'd9, 2'd1);
    queue_req(3'd6, 8'hFF, 5'd31, 2'd3);
    queue_req(3'd7, 8'h00, 5'd0, 2'd0);
    queue_req(REQ_CHAR, 8'h7E, 5'd0, 2'd0);
    queue_req(3'd7, 8'h12, 5'd4, 2'd2);
    queue_req(REQ_GOTO, 8'h00, 5'd20, 2'd2);
    wait_until_idle();

    write_all_regs(8'h00);
    queue_req(REQ_INIT, 8'h00, 5'd0, 2'd0);
    queue_req(REQ_CLEAR, 8'h00, 5'd0, 2'd0);
    queue_req(REQ_CHAR, 8'hFF, 5'd0, 2'd0);
    wait_until_idle();

    write_all_regs(8'hFF);
    queue_req(REQ_INIT, 8'h00, 5'd0, 2'd0);
    queue_req(REQ_CLEAR, 8'h00, 5'd0, 2'd0);
    queue_req(REQ_GOTO, 8'h00, 5'd16, 2'd2);
    wait_until_idle();

    // random phases with fresh register settings in between
    repeat (3) begin
      r = r.first();
      repeat (r.num()) begin
        if ($urandom_range(0, 1) == 1) write_cmd_reg(r, 8'($urandom_range(0, 255)));
        r = r.next();
      end
      end_cfg_writes();
      repeat (50) req_backlog.push_back(random_request());
      wait_until_idle();
    end

    if (mismatch_count == 0 && pin_states_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
